@@ rtl/gpfe_pkg.sv @@
// gpfe_pkg: shared types, constants and header table for the GGA field extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package gpfe_pkg;

    localparam int MAX_FIELD_CHARS = 16;
    localparam int CNT_W           = $clog2(MAX_FIELD_CHARS + 1);

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_HDR1     = 4'd1,
        PH_HDR2     = 4'd2,
        PH_HDR3     = 4'd3,
        PH_HDR4     = 4'd4,
        PH_HDR5     = 4'd5,
        PH_HDR6     = 4'd6,
        PH_SKIPTIME = 4'd7,
        PH_LAT      = 4'd8,
        PH_LATDIR   = 4'd9,
        PH_SKIP     = 4'd10,
        PH_LON      = 4'd11,
        PH_LONDIR   = 4'd12
    } phase_t;

    typedef enum logic [1:0] {
        TAG_LAT_CHAR = 2'd0,
        TAG_LAT_DIR  = 2'd1,
        TAG_LON_CHAR = 2'd2,
        TAG_LON_DIR  = 2'd3
    } tag_t;

    // one result as it leaves the parser
    typedef struct packed {
        logic       valid;
        tag_t       tag;
        logic [7:0] ch;
        logic [3:0] pos;
        logic       trunc;
        logic       done;
    } res_t;

    // expected character for header phases 0..6 ("$GPGGA,")
    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = CH_G;
            3'd2:    c = CH_P;
            3'd3:    c = CH_G;
            3'd4:    c = CH_G;
            3'd5:    c = CH_A;
            3'd6:    c = CH_COMMA;
            default: c = CH_COMMA;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gpfe_parser.sv @@
// gpfe_parser: sentence state machine; consumes one byte per step and forms the result.
// Depends on gpfe_pkg.
`default_nettype none

module gpfe_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      rx_ch,
    output gpfe_pkg::res_t       res
);
    import gpfe_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;

    logic is_comma;
    logic has_room;

    assign is_comma = (rx_ch == CH_COMMA);
    assign has_room = (count_reg < CNT_W'(MAX_FIELD_CHARS));

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

    // next state
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        unique case (phase_reg)
            PH_IDLE, PH_HDR1, PH_HDR2, PH_HDR3, PH_HDR4, PH_HDR5, PH_HDR6: begin
                if (rx_ch == hdr_char(phase_reg[2:0]))
                    phase_next = phase_t'(phase_reg + 4'd1);
                else
                    phase_next = PH_IDLE;
            end
            PH_SKIPTIME, PH_SKIP: begin
                if (is_comma) begin
                    phase_next = (phase_reg == PH_SKIPTIME) ? PH_LAT : PH_LON;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            PH_LAT, PH_LON: begin
                if (is_comma)
                    phase_next = (phase_reg == PH_LAT) ? PH_LATDIR : PH_LONDIR;
                else if (has_room)
                    count_next = count_reg + CNT_W'(1);
                else
                    ovf_next = 1'b1;
            end
            PH_LATDIR, PH_LONDIR: begin
                phase_next = (phase_reg == PH_LATDIR) ? PH_SKIP : PH_IDLE;
                count_next = '0;
                ovf_next   = 1'b0;
            end
            default: begin
                // unused codes behave as idle
                phase_next = (rx_ch == CH_DOLLAR) ? PH_HDR1 : PH_IDLE;
            end
        endcase
    end

    // result
    always_comb begin
        res.valid = 1'b0;
        res.tag   = TAG_LAT_CHAR;
        res.ch    = rx_ch;
        res.pos   = 4'd0;
        res.trunc = 1'b0;
        res.done  = 1'b0;
        unique case (phase_reg)
            PH_LAT, PH_LON: begin
                res.valid = !is_comma && has_room;
                res.tag   = (phase_reg == PH_LAT) ? TAG_LAT_CHAR : TAG_LON_CHAR;
                res.pos   = count_reg[3:0];
            end
            PH_LATDIR, PH_LONDIR: begin
                res.valid = 1'b1;
                res.tag   = (phase_reg == PH_LATDIR) ? TAG_LAT_DIR : TAG_LON_DIR;
                res.trunc = ovf_reg;
                res.done  = (phase_reg == PH_LONDIR);
            end
            default: begin
                res.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/gga_position_field_extractor_unit.sv @@
// gga_position_field_extractor_unit: top level, input register, parser and result register.
// Depends on gpfe_pkg and gpfe_parser.
`default_nettype none

// Scans a stream of received serial bytes for a "$GPGGA," header, skips the
// time field, and returns the latitude characters, the latitude direction
// byte, the longitude characters and the longitude direction byte, one result
// per character; the longitude direction result has sentence_done set. A
// byte that breaks the header is consumed and sends the scan back to idle.
// Field commas and the skipped bytes produce no result. At most
// MAX_FIELD_CHARS (16) characters of a coordinate field are returned; the
// rest are dropped and field_truncated is raised on the direction result
// that follows. Throughput is one byte per clock unless results stall: a
// request is registered on acceptance, handed to the parser once the result
// register is empty or being taken, and its result, if any, lands in the
// result register. rx_ready falls only while the result register is full and
// not being taken, so the input stage holds one request in that case. No
// clearing pass is needed after reset.
module gga_position_field_extractor_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [1:0]      field_tag,
    output logic [7:0]      char_out,
    output logic [3:0]      char_pos,
    output logic            field_truncated,
    output logic            sentence_done
);
    import gpfe_pkg::*;

    // input stage
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic       out_vld_reg, out_vld_next;
    res_t       out_reg;

    res_t       res;
    logic       step;     // input stage item handed to the parser this cycle
    logic       rx_take;

    assign step     = in_vld_reg && (!out_vld_reg || res_ready);
    assign rx_ready = !in_vld_reg || step;
    assign rx_take  = rx_valid && rx_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (rx_ready)
            in_vld_reg <= rx_valid;
    end

    always_ff @(posedge clk) begin
        if (rx_take)
            in_byte_reg <= rx_byte;
    end

    gpfe_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .rx_ch (in_byte_reg),
        .res   (res)
    );

    // result register: loads on a step, drains when taken
    always_comb begin
        out_vld_next = out_vld_reg;
        if (step)
            out_vld_next = res.valid;
        else if (res_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= out_vld_next;
    end

    always_ff @(posedge clk) begin
        if (step && res.valid)
            out_reg <= res;
    end

    assign res_valid       = out_vld_reg;
    assign field_tag       = out_reg.tag;
    assign char_out        = out_reg.ch;
    assign char_pos        = out_reg.pos;
    assign field_truncated = out_reg.trunc;
    assign sentence_done   = out_reg.done;

endmodule

`default_nettype wire

@@ rtl/gpfe_checker.sv @@
// gpfe_checker: port-level assertions for the GGA field extractor, bound to the top.
// Depends on gpfe_pkg and gga_position_field_extractor_unit.
`default_nettype none

module gpfe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_ready,
    input wire logic [1:0] field_tag,
    input wire logic [7:0] char_out,
    input wire logic [3:0] char_pos,
    input wire logic       field_truncated,
    input wire logic       sentence_done
);
    import gpfe_pkg::*;

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(char_out) && $stable(field_tag)
            && $stable(char_pos) && $stable(field_truncated) && $stable(sentence_done))
        else $error("result changed while stalled");

    // done only on the longitude direction
    a_done_tag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (sentence_done == (field_tag == TAG_LON_DIR)))
        else $error("sentence_done does not match longitude direction");

    // coordinate characters never carry the truncation flag
    a_char_flags: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (field_tag == TAG_LAT_CHAR || field_tag == TAG_LON_CHAR)
            |-> !field_truncated)
        else $error("truncation flag on a coordinate character");

    // direction results sit at position zero
    a_dir_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (field_tag == TAG_LAT_DIR || field_tag == TAG_LON_DIR)
            |-> char_pos == 4'd0)
        else $error("direction result with nonzero position");

endmodule

bind gga_position_field_extractor_unit gpfe_checker u_gpfe_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .field_tag       (field_tag),
    .char_out        (char_out),
    .char_pos        (char_pos),
    .field_truncated (field_truncated),
    .sentence_done   (sentence_done)
);

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking testbench for gga_position_field_extractor_unit.
// Depends on gpfe_pkg (phase, tag and character constants) and the unit's RTL.
// Directed byte table first, then random GGA sentences under four idling phases.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gpfe_pkg::*;

    // Cycles with no request and no result moving before the run is abandoned.
    // A correct run never gets near this, even at 56 percent idling on one side.
    localparam int WATCHDOG_LIMIT = 2000;
    // Margin after the last expected result is taken.
    localparam int DRAIN_CYCLES   = 8;
    // Bytes that the parser actually works on (noise while hunting not counted).
    localparam int RANDOM_ITEMS   = 1550;
    localparam int N_PHASES       = 4;
    localparam int N_ROWS         = 25;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;

    // Idling per phase: none, sender only, receiver only, both.
    localparam int IDLE_PCT  [N_PHASES] = '{0, 56, 0, 20};
    localparam int STALL_PCT [N_PHASES] = '{0, 0, 56, 20};

    // "$GPGGA," indexed by the header phase
    localparam logic [7:0] GGA_HDR [7] =
        '{CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A, CH_COMMA};

    // One result as seen on the output ports.
    typedef struct packed {
        tag_t       tag;
        logic [7:0] ch;
        logic [3:0] pos;
        logic       trunc;
        logic       done;
    } field_t;

    localparam field_t NO_FIELD = '0;

    // How a directed row gets its expectation: from the predictor, or typed in
    // as "no result" or as one given result.
    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_QUIET,
        ROW_RESULT
    } row_kind_t;

    typedef struct packed {
        logic [7:0] b;
        row_kind_t  kind;
        field_t     f;
    } row_t;

    // Directed table:
    //   extreme bytes while hunting,
    //   a broken header "$$" (second dollar consumed, so "GPGGA," is noise),
    //   a real header, empty time field, empty latitude field,
    //   0xFF as latitude direction, one skipped byte before the comma,
    //   a single 0x00 longitude character, and a comma taken as the
    //   longitude direction.
    row_t dir_rows [N_ROWS] = '{
        '{8'h00,     ROW_QUIET,   NO_FIELD},
        '{8'hFF,     ROW_QUIET,   NO_FIELD},
        '{CH_DOLLAR, ROW_PREDICT, NO_FIELD},
        '{CH_DOLLAR, ROW_PREDICT, NO_FIELD},
        '{CH_G,      ROW_PREDICT, NO_FIELD},
        '{CH_P,      ROW_PREDICT, NO_FIELD},
        '{CH_G,      ROW_PREDICT, NO_FIELD},
        '{CH_G,      ROW_PREDICT, NO_FIELD},
        '{CH_A,      ROW_PREDICT, NO_FIELD},
        '{CH_COMMA,  ROW_PREDICT, NO_FIELD},
        '{CH_DOLLAR, ROW_PREDICT, NO_FIELD},
        '{CH_G,      ROW_PREDICT, NO_FIELD},
        '{CH_P,      ROW_PREDICT, NO_FIELD},
        '{CH_G,      ROW_PREDICT, NO_FIELD},
        '{CH_G,      ROW_PREDICT, NO_FIELD},
        '{CH_A,      ROW_PREDICT, NO_FIELD},
        '{CH_COMMA,  ROW_PREDICT, NO_FIELD},
        '{CH_COMMA,  ROW_PREDICT, NO_FIELD},
        '{CH_COMMA,  ROW_PREDICT, NO_FIELD},
        '{8'hFF,     ROW_RESULT,  '{TAG_LAT_DIR, 8'hFF, 4'd0, 1'b0, 1'b0}},
        '{8'h45,     ROW_PREDICT, NO_FIELD},
        '{CH_COMMA,  ROW_PREDICT, NO_FIELD},
        '{8'h00,     ROW_RESULT,  '{TAG_LON_CHAR, 8'h00, 4'd0, 1'b0, 1'b0}},
        '{CH_COMMA,  ROW_PREDICT, NO_FIELD},
        '{CH_COMMA,  ROW_RESULT,  '{TAG_LON_DIR, CH_COMMA, 4'd0, 1'b0, 1'b1}}
    };

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic       rx_ready;
    logic [7:0] rx_byte   = 8'h00;
    logic       res_valid;
    logic       res_ready = 1'b0;
    logic [1:0] field_tag;
    logic [7:0] char_out;
    logic [3:0] char_pos;
    logic       field_truncated;
    logic       sentence_done;

    // Parser state as the testbench tracks it.
    phase_t     gga_phase = PH_IDLE;
    logic [4:0] gga_count = '0;
    logic       gga_ovf   = 1'b0;

    field_t     pending_fields [$];
    logic [7:0] byte_stream [$];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    gga_position_field_extractor_unit u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_ready        (rx_ready),
        .rx_byte         (rx_byte),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .field_tag       (field_tag),
        .char_out        (char_out),
        .char_pos        (char_pos),
        .field_truncated (field_truncated),
        .sentence_done   (sentence_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Advance the tracked parser by one accepted byte; hit is set when the
    // byte produces a result, which is returned in f.
    function automatic void track_gga(input logic [7:0] b, output bit hit,
                                      output field_t f);
        hit = 1'b0;
        f   = NO_FIELD;
        if (gga_phase < PH_SKIPTIME)
        begin
            // header match; a mismatching byte is eaten, even a dollar
            if (b == GGA_HDR[gga_phase])
                gga_phase = phase_t'(gga_phase + 4'd1);
            else
                gga_phase = PH_IDLE;
        end
        else
        begin
            case (gga_phase)
                PH_SKIPTIME, PH_SKIP:
                begin
                    if (b == CH_COMMA)
                    begin
                        if (gga_phase == PH_SKIPTIME)
                            gga_phase = PH_LAT;
                        else
                            gga_phase = PH_LON;
                        gga_count = '0;
                        gga_ovf   = 1'b0;
                    end
                end
                PH_LAT, PH_LON:
                begin
                    if (b == CH_COMMA)
                    begin
                        // field comma gives no result
                        if (gga_phase == PH_LAT)
                            gga_phase = PH_LATDIR;
                        else
                            gga_phase = PH_LONDIR;
                    end
                    else if (gga_count < MAX_FIELD_CHARS)
                    begin
                        hit = 1'b1;
                        if (gga_phase == PH_LAT)
                            f.tag = TAG_LAT_CHAR;
                        else
                            f.tag = TAG_LON_CHAR;
                        f.ch      = b;
                        f.pos     = gga_count[3:0];
                        gga_count = gga_count + 5'd1;
                    end
                    else
                    begin
                        // overlong field: dropped, flagged on the direction
                        gga_ovf = 1'b1;
                    end
                end
                PH_LATDIR, PH_LONDIR:
                begin
                    // any byte is the direction, a comma included
                    hit     = 1'b1;
                    f.ch    = b;
                    f.pos   = 4'd0;
                    f.trunc = gga_ovf;
                    if (gga_phase == PH_LATDIR)
                    begin
                        f.tag     = TAG_LAT_DIR;
                        f.done    = 1'b0;
                        gga_phase = PH_SKIP;
                    end
                    else
                    begin
                        f.tag     = TAG_LON_DIR;
                        f.done    = 1'b1;
                        gga_phase = PH_IDLE;
                    end
                    gga_count = '0;
                    gga_ovf   = 1'b0;
                end
                default:
                begin
                    // codes past the longitude direction act as idle
                    if (b == CH_DOLLAR)
                        gga_phase = PH_HDR1;
                    else
                        gga_phase = PH_IDLE;
                end
            endcase
        end
    endfunction

    // Mostly digits and dots, sometimes any byte but a comma.
    function automatic logic [7:0] coord_char();
        logic [7:0] c;
        if ($urandom_range(3) != 0)
        begin
            if ($urandom_range(10) == 10)
                return CH_DOT;
            return CH_ZERO + 8'($urandom_range(9));
        end
        do
            c = 8'($urandom_range(255));
        while (c == CH_COMMA);
        return c;
    endfunction

    // Field body of n characters, then its comma.
    task automatic queue_field(input int n);
        repeat (n) byte_stream.push_back(coord_char());
        byte_stream.push_back(CH_COMMA);
    endtask

    // One random sentence: leading noise, then mostly a well-formed GGA
    // sentence with random content, sometimes a broken header or a sentence
    // cut short after the latitude.
    task automatic queue_sentence();
        int         cut;
        logic [7:0] bad;
        if ($urandom_range(1) == 0)
            repeat ($urandom_range(3)) byte_stream.push_back(8'($urandom_range(255)));
        if ($urandom_range(7) == 0)
        begin
            cut = $urandom_range(6);
            for (int k = 0; k < cut; k++)
                byte_stream.push_back(GGA_HDR[k]);
            // breaking byte, often a dollar
            if ($urandom_range(2) == 0)
                bad = CH_DOLLAR;
            else
                bad = 8'($urandom_range(255));
            if (bad == GGA_HDR[cut])
                bad = bad ^ 8'h01;
            byte_stream.push_back(bad);
            return;
        end
        for (int k = 0; k < 7; k++)
            byte_stream.push_back(GGA_HDR[k]);
        queue_field($urandom_range(9));
        // latitude: mostly fits, now and then overlong
        if ($urandom_range(5) == 0)
            queue_field($urandom_range(24, 13));
        else
            queue_field($urandom_range(12));
        if ($urandom_range(7) == 0)
            byte_stream.push_back(CH_COMMA);
        else
            byte_stream.push_back(8'($urandom_range(255)));
        if ($urandom_range(9) == 0)
            return;
        // bytes skipped before the longitude comma
        repeat ($urandom_range(3)) byte_stream.push_back(coord_char());
        byte_stream.push_back(CH_COMMA);
        if ($urandom_range(5) == 0)
            queue_field($urandom_range(24, 13));
        else
            queue_field($urandom_range(12));
        if ($urandom_range(7) == 0)
            byte_stream.push_back(CH_COMMA);
        else
            byte_stream.push_back(8'($urandom_range(255)));
    endtask

    // Offer one byte as an rx request, wait for acceptance and record what it
    // should produce. Returns at the accepting edge.
    task automatic offer_byte(input logic [7:0] b, input row_kind_t kind,
                              input field_t typed);
        bit     hit;
        field_t f;
        while ($urandom_range(99) < idle_pct)
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        track_gga(b, hit, f);
        if (kind == ROW_QUIET)
            hit = 1'b0;
        else if (kind == ROW_RESULT)
        begin
            hit = 1'b1;
            f   = typed;
        end
        if (hit)
            pending_fields.push_back(f);
    endtask

    // Receiver: random stalls at the rate of the current phase.
    always @(posedge clk)
        res_ready <= ($urandom_range(99) >= stall_pct);

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        field_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_fields.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result tag=%0d ch=%h pos=%0d trunc=%b done=%b",
                             $realtime, field_tag, char_out, char_pos,
                             field_truncated, sentence_done);
            end
            else
            begin
                want = pending_fields.pop_front();
                if (field_tag !== want.tag || char_out !== want.ch ||
                    char_pos !== want.pos || field_truncated !== want.trunc ||
                    sentence_done !== want.done)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch exp tag=%0d ch=%h pos=%0d trunc=%b done=%b,",
                                 $realtime, want.tag, want.ch, want.pos, want.trunc,
                                 want.done, " got tag=%0d ch=%h pos=%0d trunc=%b done=%b",
                                 field_tag, char_out, char_pos,
                                 field_truncated, sentence_done);
                end
            end
        end
    end

    // Watchdog: no request and no result moving for too long means a hang.
    always @(posedge clk)
    begin
        if ((rx_valid && rx_ready) || (res_valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("gga_position_field_extractor_unit test failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, four random phases, drain.
    initial
    begin
        logic [7:0] nb;
        int         busy_items;
        busy_items = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, no idling
        for (int r = 0; r < N_ROWS; r++)
            offer_byte(dir_rows[r].b, dir_rows[r].kind, dir_rows[r].f);

        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_pct  = IDLE_PCT[p];
            stall_pct = STALL_PCT[p];
            while (busy_items < (p + 1) * RANDOM_ITEMS / N_PHASES)
            begin
                if (byte_stream.size() == 0)
                    queue_sentence();
                nb = byte_stream.pop_front();
                // bytes eaten while hunting for a dollar do not count
                if (gga_phase != PH_IDLE)
                    busy_items++;
                offer_byte(nb, ROW_PREDICT, NO_FIELD);
            end
        end

        rx_valid <= 1'b0;
        while (pending_fields.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("gga_position_field_extractor_unit test passed");
        else
            $display("gga_position_field_extractor_unit test failed");
        $finish;
    end

endmodule
